>>> rtl/fwqi_pkg.sv
package fwqi_pkg;

    // Field widths
    localparam int HARDNESS_BITS = 12;
    localparam int CHLORIDE_BITS = 8;
    localparam int CENTROID_BITS = 8;
    localparam int FIELD_BITS    = 16;

    // Membership fraction bits (one = 1 << FRACTION_BITS)
    localparam int FRACTION_BITS = 15;
    localparam int MEM_W         = FRACTION_BITS + 1;

    // Defuzzifier widths
    localparam int QUAL_FRAC = 8;
    localparam int DEN_W     = MEM_W + 2;
    localparam int WPROD_W   = MEM_W + CENTROID_BITS;
    localparam int NUM_W     = WPROD_W + 2 + QUAL_FRAC;

    // Divider: quotient bits and bits retired per stage
    localparam int QUOT_W     = FIELD_BITS;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = QUOT_W / DIV_STEP;

    // Configuration register map
    localparam int REG_INDEX_W = 2;
    localparam logic [REG_INDEX_W-1:0] REG_CENTROID_A = REG_INDEX_W'(0);
    localparam logic [REG_INDEX_W-1:0] REG_CENTROID_B = REG_INDEX_W'(1);
    localparam logic [REG_INDEX_W-1:0] REG_CENTROID_C = REG_INDEX_W'(2);

    localparam logic [CENTROID_BITS-1:0] CENTROID_A_RESET = CENTROID_BITS'(19);
    localparam logic [CENTROID_BITS-1:0] CENTROID_B_RESET = CENTROID_BITS'(40);
    localparam logic [CENTROID_BITS-1:0] CENTROID_C_RESET = CENTROID_BITS'(67);

    typedef struct packed {
        logic [HARDNESS_BITS-1:0] hardness_ppm;
        logic [CHLORIDE_BITS-1:0] chloride_level;
    } in_beat_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] strength_a;
        logic [FIELD_BITS-1:0] strength_b;
        logic [FIELD_BITS-1:0] strength_c;
        logic [FIELD_BITS-1:0] crisp_quality;
    } out_beat_t;

    // Beat handed from the inference front end to the divider
    typedef struct packed {
        logic [NUM_W-1:0]      num;
        logic [DEN_W-1:0]      den;
        logic [FIELD_BITS-1:0] strength_a;
        logic [FIELD_BITS-1:0] strength_b;
        logic [FIELD_BITS-1:0] strength_c;
    } div_beat_t;

endpackage

>>> rtl/fuzzy_water_quality_inference.sv
// Channel  | Ports                         | Beat
// ---------+-------------------------------+---------------------------------------------
// input    | s_valid s_ready s_data        | hardness_ppm, chloride_level
// result   | m_valid m_ready m_data        | strength_a/b/c (Q1.15), crisp_quality (Q8.8)
// config   | cfg_we cfg_index cfg_wdata    | centroid_a/b/c, one write per cycle
//
// One beat per cycle sustained while m_ready is high; six inference stages plus the
// eight-stage divider, which retires two quotient bits per stage.
// Reset clears all valid bits and loads centroids 19, 40 and 67; there is no clearing pass.
// A stage holds its beat while the stage after it is full and stalled; empty stages
// fill up behind a stalled output, so input is taken until the pipe is full.
module fuzzy_water_quality_inference (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  fwqi_pkg::in_beat_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output fwqi_pkg::out_beat_t                 m_data,
    input  logic                                cfg_we,
    input  logic [fwqi_pkg::REG_INDEX_W-1:0]    cfg_index,
    input  logic [fwqi_pkg::CENTROID_BITS-1:0]  cfg_wdata
);
    import fwqi_pkg::*;

    // Membership segment codes
    localparam logic [2:0] SEG_LOW  = 3'd0;
    localparam logic [2:0] SEG_RISE = 3'd1;
    localparam logic [2:0] SEG_MID  = 3'd2;
    localparam logic [2:0] SEG_FALL = 3'd3;
    localparam logic [2:0] SEG_HIGH = 3'd4;

    // Breakpoints
    localparam logic [HARDNESS_BITS-1:0] H_LO  = HARDNESS_BITS'(75);
    localparam logic [HARDNESS_BITS-1:0] H_MID = HARDNESS_BITS'(150);
    localparam logic [HARDNESS_BITS-1:0] H_HI  = HARDNESS_BITS'(300);
    localparam logic [CHLORIDE_BITS-1:0] C_LO  = CHLORIDE_BITS'(2);
    localparam logic [CHLORIDE_BITS-1:0] C_MID = CHLORIDE_BITS'(5);
    localparam logic [CHLORIDE_BITS-1:0] C_HI  = CHLORIDE_BITS'(8);

    // Hardness spans and their reciprocals
    localparam int KH_W        = 8;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = FRACTION_BITS + RECIP_SHIFT - 6;
    localparam int PROD_W      = KH_W + RECIP_W;
    localparam int REM_W       = KH_W + FRACTION_BITS;
    localparam logic [KH_W-1:0] H_SPAN_RISE = KH_W'(75);
    localparam logic [KH_W-1:0] H_SPAN_FALL = KH_W'(150);
    localparam logic [RECIP_W-1:0] RECIP_RISE =
        RECIP_W'((64'd1 << (FRACTION_BITS + RECIP_SHIFT)) / 75);
    localparam logic [RECIP_W-1:0] RECIP_FALL =
        RECIP_W'((64'd1 << (FRACTION_BITS + RECIP_SHIFT)) / 150);

    // Fixed-point one and chloride thirds
    localparam logic [MEM_W-1:0] ONE_FX     = MEM_W'(1) << FRACTION_BITS;
    localparam logic [MEM_W-1:0] ONE_THIRD  = MEM_W'((64'd1 << FRACTION_BITS) / 3);
    localparam logic [MEM_W-1:0] TWO_THIRDS = MEM_W'((64'd2 << FRACTION_BITS) / 3);

    localparam logic [FIELD_BITS-1:0] QUALITY_MAX =
        FIELD_BITS'(((1 << CENTROID_BITS) - 1) << QUAL_FRAC);

    typedef struct packed {
        logic [2:0]            h_seg;
        logic [KH_W-1:0]       h_ka;
        logic [KH_W-1:0]       h_kb;
        logic [2:0][MEM_W-1:0] c_mem;
    } st1_t;

    typedef struct packed {
        logic [2:0]            h_seg;
        logic [KH_W-1:0]       h_ka;
        logic [KH_W-1:0]       h_kb;
        logic [PROD_W-1:0]     h_pa;
        logic [PROD_W-1:0]     h_pb;
        logic [2:0][MEM_W-1:0] c_mem;
    } st2_t;

    typedef struct packed {
        logic [2:0][MEM_W-1:0] h_mem;
        logic [2:0][MEM_W-1:0] c_mem;
    } st3_t;

    typedef struct packed {
        logic [MEM_W-1:0] sa;
        logic [MEM_W-1:0] sb;
        logic [MEM_W-1:0] sc;
    } st4_t;

    typedef struct packed {
        logic [WPROD_W-1:0] wa;
        logic [WPROD_W-1:0] wb;
        logic [WPROD_W-1:0] wc;
        logic [DEN_W-1:0]   den;
        logic [MEM_W-1:0]   sa;
        logic [MEM_W-1:0]   sb;
        logic [MEM_W-1:0]   sc;
    } st5_t;

    logic [CENTROID_BITS-1:0] cent_a_reg, cent_b_reg, cent_c_reg;

    st1_t      st1_reg, st1_next;
    st2_t      st2_reg, st2_next;
    st3_t      st3_reg, st3_next;
    st4_t      st4_reg, st4_next;
    st5_t      st5_reg, st5_next;
    div_beat_t st6_reg, st6_next;
    logic      v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic      en1, en2, en3, en4, en5, en6;
    logic      div_ready;

    function automatic logic [MEM_W-1:0] lesser(input logic [MEM_W-1:0] p,
                                                 input logic [MEM_W-1:0] q);
        return (p < q) ? p : q;
    endfunction

    function automatic logic [MEM_W-1:0] greater(input logic [MEM_W-1:0] p,
                                                  input logic [MEM_W-1:0] q);
        return (p > q) ? p : q;
    endfunction

    function automatic logic [MEM_W-1:0] third(input logic [1:0] k);
        return k[1] ? TWO_THIRDS : ONE_THIRD;
    endfunction

    // Reciprocal estimate is at most one low; one compare fixes it
    function automatic logic [MEM_W-1:0] fix_quot(input logic [KH_W-1:0]   k,
                                                   input logic [PROD_W-1:0] prod,
                                                   input logic [KH_W-1:0]   span);
        logic [FRACTION_BITS-1:0] qe;
        logic [REM_W-1:0]         rem;
        qe  = prod[RECIP_SHIFT +: FRACTION_BITS];
        rem = {k, {FRACTION_BITS{1'b0}}} - REM_W'(qe) * REM_W'(span);
        return MEM_W'(qe) + MEM_W'(rem >= REM_W'(span));
    endfunction

    // Centroid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cent_a_reg <= CENTROID_A_RESET;
            cent_b_reg <= CENTROID_B_RESET;
            cent_c_reg <= CENTROID_C_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CENTROID_A: cent_a_reg <= cfg_wdata;
                REG_CENTROID_B: cent_b_reg <= cfg_wdata;
                REG_CENTROID_C: cent_c_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage 1: segment select, hardness numerators, chloride memberships
    always_comb begin
        logic [HARDNESS_BITS-1:0] hv;
        logic [CHLORIDE_BITS-1:0] cv;
        hv       = s_data.hardness_ppm;
        cv       = s_data.chloride_level;
        st1_next = '0;
        if (hv <= H_LO) begin
            st1_next.h_seg = SEG_LOW;
        end else if (hv < H_MID) begin
            st1_next.h_seg = SEG_RISE;
            st1_next.h_ka  = KH_W'(H_MID - hv);
            st1_next.h_kb  = KH_W'(hv - H_LO);
        end else if (hv == H_MID) begin
            st1_next.h_seg = SEG_MID;
        end else if (hv < H_HI) begin
            st1_next.h_seg = SEG_FALL;
            st1_next.h_ka  = KH_W'(H_HI - hv);
            st1_next.h_kb  = KH_W'(hv - H_MID);
        end else begin
            st1_next.h_seg = SEG_HIGH;
        end
        if (cv <= C_LO) begin
            st1_next.c_mem[0] = ONE_FX;
        end else if (cv < C_MID) begin
            st1_next.c_mem[0] = third(2'(C_MID - cv));
            st1_next.c_mem[1] = third(2'(cv - C_LO));
        end else if (cv == C_MID) begin
            st1_next.c_mem[1] = ONE_FX;
        end else if (cv < C_HI) begin
            st1_next.c_mem[1] = third(2'(C_HI - cv));
            st1_next.c_mem[2] = third(2'(cv - C_MID));
        end else begin
            st1_next.c_mem[2] = ONE_FX;
        end
    end

    // Stage 2: multiply by span reciprocal
    always_comb begin
        logic [RECIP_W-1:0] recip;
        recip          = (st1_reg.h_seg == SEG_FALL) ? RECIP_FALL : RECIP_RISE;
        st2_next.h_seg = st1_reg.h_seg;
        st2_next.h_ka  = st1_reg.h_ka;
        st2_next.h_kb  = st1_reg.h_kb;
        st2_next.h_pa  = PROD_W'(st1_reg.h_ka) * PROD_W'(recip);
        st2_next.h_pb  = PROD_W'(st1_reg.h_kb) * PROD_W'(recip);
        st2_next.c_mem = st1_reg.c_mem;
    end

    // Stage 3: quotient correction and hardness memberships
    always_comb begin
        logic [KH_W-1:0]  span;
        logic [MEM_W-1:0] qa, qb;
        span           = (st2_reg.h_seg == SEG_FALL) ? H_SPAN_FALL : H_SPAN_RISE;
        qa             = fix_quot(st2_reg.h_ka, st2_reg.h_pa, span);
        qb             = fix_quot(st2_reg.h_kb, st2_reg.h_pb, span);
        st3_next.h_mem = '0;
        st3_next.c_mem = st2_reg.c_mem;
        unique case (st2_reg.h_seg)
            SEG_LOW:  st3_next.h_mem[0] = ONE_FX;
            SEG_RISE: begin
                st3_next.h_mem[0] = qa;
                st3_next.h_mem[1] = qb;
            end
            SEG_MID:  st3_next.h_mem[1] = ONE_FX;
            SEG_FALL: begin
                st3_next.h_mem[1] = qa;
                st3_next.h_mem[2] = qb;
            end
            SEG_HIGH: st3_next.h_mem[2] = ONE_FX;
            default:  st3_next.h_mem = '0;
        endcase
    end

    // Stage 4: min rules, max per class
    always_comb begin
        st4_next.sa = greater(greater(lesser(st3_reg.h_mem[0], st3_reg.c_mem[0]),
                                      lesser(st3_reg.h_mem[0], st3_reg.c_mem[1])),
                              lesser(st3_reg.h_mem[1], st3_reg.c_mem[0]));
        st4_next.sb = greater(greater(lesser(st3_reg.h_mem[0], st3_reg.c_mem[2]),
                                      lesser(st3_reg.h_mem[1], st3_reg.c_mem[1])),
                              lesser(st3_reg.h_mem[2], st3_reg.c_mem[0]));
        st4_next.sc = greater(greater(lesser(st3_reg.h_mem[1], st3_reg.c_mem[2]),
                                      lesser(st3_reg.h_mem[2], st3_reg.c_mem[1])),
                              lesser(st3_reg.h_mem[2], st3_reg.c_mem[2]));
    end

    // Stage 5: weight by centroids, strength sum
    always_comb begin
        st5_next.wa  = WPROD_W'(st4_reg.sa) * WPROD_W'(cent_a_reg);
        st5_next.wb  = WPROD_W'(st4_reg.sb) * WPROD_W'(cent_b_reg);
        st5_next.wc  = WPROD_W'(st4_reg.sc) * WPROD_W'(cent_c_reg);
        st5_next.den = DEN_W'(st4_reg.sa) + DEN_W'(st4_reg.sb) + DEN_W'(st4_reg.sc);
        st5_next.sa  = st4_reg.sa;
        st5_next.sb  = st4_reg.sb;
        st5_next.sc  = st4_reg.sc;
    end

    // Stage 6: numerator in Q8.8 scale
    always_comb begin
        st6_next.num = (NUM_W'(st5_reg.wa) + NUM_W'(st5_reg.wb) + NUM_W'(st5_reg.wc))
                       << QUAL_FRAC;
        st6_next.den        = st5_reg.den;
        st6_next.strength_a = FIELD_BITS'(st5_reg.sa);
        st6_next.strength_b = FIELD_BITS'(st5_reg.sb);
        st6_next.strength_c = FIELD_BITS'(st5_reg.sc);
    end

    // Stage enables
    assign en6     = !v6_reg || div_ready;
    assign en5     = !v5_reg || en6;
    assign en4     = !v4_reg || en5;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) st1_reg <= st1_next;
        if (en2) st2_reg <= st2_next;
        if (en3) st3_reg <= st3_next;
        if (en4) st4_reg <= st4_next;
        if (en5) st5_reg <= st5_next;
        if (en6) st6_reg <= st6_next;
    end

    fwqi_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v6_reg),
        .in_ready  (div_ready),
        .in_data   (st6_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

`ifndef SYNTH
    // Some rule always fires, so the divisor is never zero
    a_strength_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg |-> ((st4_reg.sa | st4_reg.sb | st4_reg.sc) != '0))
        else $error("all class strengths zero");

    a_strength_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg |-> (st4_reg.sa <= ONE_FX && st4_reg.sb <= ONE_FX && st4_reg.sc <= ONE_FX))
        else $error("class strength above one");

    // Input is refused only when the whole pipe backs up behind the output
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input refused without an output stall");

    a_quality_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.crisp_quality <= QUALITY_MAX))
        else $error("crisp quality beyond largest centroid");
`endif

endmodule

>>> rtl/fwqi_div.sv
module fwqi_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  fwqi_pkg::div_beat_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fwqi_pkg::out_beat_t out_data
);
    import fwqi_pkg::*;

    typedef struct packed {
        logic [DEN_W-1:0]      rem;
        logic [QUOT_W-1:0]     bits;   // numerator bits shift out, quotient bits shift in
        logic [DEN_W-1:0]      den;
        logic                  zero;
        logic [FIELD_BITS-1:0] sa;
        logic [FIELD_BITS-1:0] sb;
        logic [FIELD_BITS-1:0] sc;
    } lane_t;

    lane_t                 st_reg  [DIV_STAGES];
    lane_t                 st_next [DIV_STAGES];
    lane_t                 entry;
    logic [DIV_STAGES-1:0] valid_reg;
    logic [DIV_STAGES-1:0] en;

    // Restoring division, DIV_STEP quotient bits
    function automatic lane_t div_step(input lane_t x);
        lane_t          y;
        logic [DEN_W:0] trial;
        y = x;
        for (int j = 0; j < DIV_STEP; j++) begin
            trial = {y.rem, y.bits[QUOT_W-1]};
            if (trial >= {1'b0, y.den}) begin
                y.rem  = DEN_W'(trial - {1'b0, y.den});
                y.bits = {y.bits[QUOT_W-2:0], 1'b1};
            end else begin
                y.rem  = trial[DEN_W-1:0];
                y.bits = {y.bits[QUOT_W-2:0], 1'b0};
            end
        end
        return y;
    endfunction

    // Quotient fits QUOT_W bits, so the upper numerator part is below den
    always_comb begin
        entry.rem  = in_data.num[NUM_W-1:QUOT_W];
        entry.bits = in_data.num[QUOT_W-1:0];
        entry.den  = in_data.den;
        entry.zero = (in_data.den == '0);
        entry.sa   = in_data.strength_a;
        entry.sb   = in_data.strength_b;
        entry.sc   = in_data.strength_c;
    end

    always_comb begin
        st_next[0] = div_step(entry);
        for (int k = 1; k < DIV_STAGES; k++) begin
            st_next[k] = div_step(st_reg[k-1]);
        end
    end

    // A stage advances when empty or when the one after it advances
    always_comb begin
        en[DIV_STAGES-1] = !valid_reg[DIV_STAGES-1] || out_ready;
        for (int k = DIV_STAGES - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < DIV_STAGES; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (en[k]) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    // Last stage is the output register
    assign out_valid              = valid_reg[DIV_STAGES-1];
    assign out_data.strength_a    = st_reg[DIV_STAGES-1].sa;
    assign out_data.strength_b    = st_reg[DIV_STAGES-1].sb;
    assign out_data.strength_c    = st_reg[DIV_STAGES-1].sc;
    assign out_data.crisp_quality = st_reg[DIV_STAGES-1].zero ? '0 : st_reg[DIV_STAGES-1].bits;

endmodule
